[rtl/core/phb_pkg.sv]
// Shared widths, codes and defaults of the periodic heartbeat table.
package phb_pkg;

  // Field widths fixed by the item format
  localparam int OP_W   = 2;
  localparam int ID_W   = 16;
  localparam int IV_W   = 16;
  localparam int KIND_W = 2;
  localparam int ANS_W  = 15;
  localparam int PER_W  = 15;

  // Parameter defaults
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int ID_BITS_DEF     = 16;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_SET   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  // Set status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } set_st_t;

  // Memory port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

[rtl/core/phb_ifs.sv]
// Request and result channel interfaces of the periodic heartbeat table.
interface phb_in_if;
  logic                       valid;
  logic                       ready;
  logic [phb_pkg::OP_W-1:0]   operation;
  logic [phb_pkg::ID_W-1:0]   object_id;
  logic signed [phb_pkg::IV_W-1:0] interval;

  modport source (output valid, output operation, output object_id, output interval,
                  input ready);
  modport sink   (input valid, input operation, input object_id, input interval,
                  output ready);
endinterface

interface phb_out_if;
  logic                       valid;
  logic                       ready;
  logic [phb_pkg::KIND_W-1:0] kind;
  logic [phb_pkg::ID_W-1:0]   fired_or_asked_id;
  logic [phb_pkg::ANS_W-1:0]  answer;
  logic                       last;

  modport source (output valid, output kind, output fired_or_asked_id, output answer,
                  output last, input ready);
  modport sink   (input valid, input kind, input fired_or_asked_id, input answer,
                  input last, output ready);
endinterface

[rtl/core/phb_ram.sv]
// Generic single-write, single-read memory with registered read data.
module phb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port that holds its data while idle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/phb_engine.sv]
// Sequencer that walks the timer memory for tick, set and query transactions.
module phb_engine #(
  parameter int TABLE_DEPTH = phb_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = phb_pkg::ID_BITS_DEF,
  localparam int OWN_W      = (ID_BITS < phb_pkg::ID_W) ? ID_BITS : phb_pkg::ID_W,
  localparam int ENT_W      = OWN_W + 2 * phb_pkg::PER_W,
  localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  phb_in_if.sink              in_chan,
  phb_out_if.source           out_chan,
  output phb_pkg::ram_ctl_t   ram_ctl,
  output logic [IDX_W-1:0]    ram_wr_addr,
  output logic [ENT_W-1:0]    ram_wr_data,
  output logic [IDX_W-1:0]    ram_rd_addr,
  input  logic [ENT_W-1:0]    ram_rd_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int PER_W = phb_pkg::PER_W;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;

  state_t                     state_r, state_nxt;
  phb_pkg::op_t               op_r, op_nxt;
  logic [OWN_W-1:0]           id_r, id_nxt;
  logic [PER_W-1:0]           iv_r, iv_nxt;
  logic                       rm_r, rm_nxt;
  logic [CNT_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic                       p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]           p_idx_r, p_idx_nxt;
  logic [TABLE_DEPTH-1:0]     live_r, live_nxt;
  logic [CNT_W-1:0]           slot_cnt_r, slot_cnt_nxt;
  phb_pkg::kind_t             fin_kind_r, fin_kind_nxt;
  logic [phb_pkg::ID_W-1:0]   fin_id_r, fin_id_nxt;
  logic [phb_pkg::ANS_W-1:0]  fin_ans_r, fin_ans_nxt;
  logic                       out_vld_r, out_vld_nxt;
  phb_pkg::kind_t             out_kind_r, out_kind_nxt;
  logic [phb_pkg::ID_W-1:0]   out_id_r, out_id_nxt;
  logic [phb_pkg::ANS_W-1:0]  out_ans_r, out_ans_nxt;
  logic                       out_last_r, out_last_nxt;

  // Fields of the entry coming out of the memory
  logic [OWN_W-1:0] ent_owner;
  logic [PER_W-1:0] ent_rem;
  logic [PER_W-1:0] ent_per;

  assign ent_owner = ram_rd_data[ENT_W-1 -: OWN_W];
  assign ent_rem   = ram_rd_data[2*PER_W-1 -: PER_W];
  assign ent_per   = ram_rd_data[PER_W-1:0];

  assign in_chan.ready              = (state_r == S_IDLE);
  assign out_chan.valid             = out_vld_r;
  assign out_chan.kind              = out_kind_r;
  assign out_chan.fired_or_asked_id = out_id_r;
  assign out_chan.answer            = out_ans_r;
  assign out_chan.last              = out_last_r;

  // Walk control, read-modify-write of entries and result emission
  always_comb begin
    logic             out_free;
    logic             live_hit;
    logic             fire;
    logic             go;
    logic             hit;
    logic [PER_W-1:0] new_rem;

    state_nxt    = state_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    iv_nxt       = iv_r;
    rm_nxt       = rm_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    p_vld_nxt    = p_vld_r;
    p_idx_nxt    = p_idx_r;
    live_nxt     = live_r;
    slot_cnt_nxt = slot_cnt_r;
    fin_kind_nxt = fin_kind_r;
    fin_id_nxt   = fin_id_r;
    fin_ans_nxt  = fin_ans_r;
    out_vld_nxt  = out_vld_r;
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_ans_nxt  = out_ans_r;
    out_last_nxt = out_last_r;
    ram_ctl      = '0;
    ram_wr_addr  = p_idx_r;
    ram_wr_data  = ram_rd_data;
    ram_rd_addr  = rd_ptr_r[IDX_W-1:0];

    out_free = !out_vld_r || out_chan.ready;
    live_hit = p_vld_r && live_r[p_idx_r];
    fire     = (ent_rem <= PER_W'(1));
    new_rem  = fire ? ent_per : ent_rem - PER_W'(1);
    go       = 1'b1;
    hit      = 1'b0;

    // Drop the result once the sink takes it
    if (out_vld_r && out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt     = phb_pkg::op_t'(in_chan.operation);
          id_nxt     = in_chan.object_id[OWN_W-1:0];
          iv_nxt     = in_chan.interval[phb_pkg::IV_W-1] ? PER_W'(1)
                                                         : in_chan.interval[PER_W-1:0];
          rm_nxt     = (in_chan.interval == '0);
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          p_vld_nxt  = 1'b0;
          if (phb_pkg::op_t'(in_chan.operation) != phb_pkg::OP_NONE) begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        // Process the entry held in the memory's read data register
        if (p_vld_r) begin
          unique case (op_r)
            phb_pkg::OP_TICK: begin
              if (live_hit) begin
                go = !fire || out_free;
                if (go) begin
                  // Squeeze the live entry down to the write pointer
                  ram_ctl.wr_en = 1'b1;
                  ram_wr_addr   = wr_ptr_r[IDX_W-1:0];
                  ram_wr_data   = {ent_owner, new_rem, ent_per};
                  wr_ptr_nxt    = wr_ptr_r + CNT_W'(1);
                  if (fire) begin
                    out_vld_nxt  = 1'b1;
                    out_kind_nxt = phb_pkg::KIND_FIRED;
                    out_id_nxt   = phb_pkg::ID_W'(ent_owner);
                    out_ans_nxt  = '0;
                    out_last_nxt = 1'b0;
                  end
                end
              end
            end
            phb_pkg::OP_SET, phb_pkg::OP_QUERY: begin
              hit = live_hit && (ent_owner == id_r);
              if (hit) begin
                fin_kind_nxt = (op_r == phb_pkg::OP_SET) ? phb_pkg::KIND_SET
                                                         : phb_pkg::KIND_QUERY;
                fin_id_nxt   = phb_pkg::ID_W'(id_r);
                if (op_r == phb_pkg::OP_QUERY) begin
                  fin_ans_nxt = ent_per;
                end else if (rm_r) begin
                  live_nxt[p_idx_r] = 1'b0;
                  fin_ans_nxt       = phb_pkg::ANS_W'(phb_pkg::ST_REMOVED);
                end else begin
                  ram_ctl.wr_en = 1'b1;
                  ram_wr_addr   = p_idx_r;
                  ram_wr_data   = {ent_owner, iv_r, iv_r};
                  fin_ans_nxt   = phb_pkg::ANS_W'(phb_pkg::ST_OK);
                end
                p_vld_nxt = 1'b0;
                state_nxt = S_FIN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end

        // Issue the next read
        if (!hit && (!p_vld_r || go)) begin
          if (rd_ptr_r < slot_cnt_r) begin
            ram_ctl.rd_en = 1'b1;
            ram_rd_addr   = rd_ptr_r[IDX_W-1:0];
            p_vld_nxt     = 1'b1;
            p_idx_nxt     = rd_ptr_r[IDX_W-1:0];
            rd_ptr_nxt    = rd_ptr_r + CNT_W'(1);
          end else begin
            p_vld_nxt = 1'b0;
          end
        end

        // Close the walk once every occupied slot has gone by
        if (!p_vld_r && (rd_ptr_r == slot_cnt_r)) begin
          state_nxt  = S_FIN;
          fin_id_nxt = phb_pkg::ID_W'(id_r);
          unique case (op_r)
            phb_pkg::OP_TICK: begin
              for (int i = 0; i < TABLE_DEPTH; i++) begin
                live_nxt[i] = (CNT_W'(i) < wr_ptr_r);
              end
              slot_cnt_nxt = wr_ptr_r;
              fin_kind_nxt = phb_pkg::KIND_DONE;
              fin_id_nxt   = '0;
              fin_ans_nxt  = '0;
            end
            phb_pkg::OP_QUERY: begin
              fin_kind_nxt = phb_pkg::KIND_QUERY;
              fin_ans_nxt  = '0;
            end
            phb_pkg::OP_SET: begin
              fin_kind_nxt = phb_pkg::KIND_SET;
              if (rm_r) begin
                fin_ans_nxt = phb_pkg::ANS_W'(phb_pkg::ST_NOT_FOUND);
              end else if (slot_cnt_r == CNT_W'(TABLE_DEPTH)) begin
                fin_ans_nxt = phb_pkg::ANS_W'(phb_pkg::ST_FULL);
              end else begin
                // Append a new timer behind the occupied slots
                ram_ctl.wr_en = 1'b1;
                ram_wr_addr   = slot_cnt_r[IDX_W-1:0];
                ram_wr_data   = {id_r, iv_r, iv_r};
                live_nxt[slot_cnt_r[IDX_W-1:0]] = 1'b1;
                slot_cnt_nxt  = slot_cnt_r + CNT_W'(1);
                fin_ans_nxt   = phb_pkg::ANS_W'(phb_pkg::ST_OK);
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_FIN: begin
        // Hand out the closing transaction
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = fin_kind_r;
          out_id_nxt   = fin_id_r;
          out_ans_nxt  = fin_ans_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    iv_r       <= iv_nxt;
    rm_r       <= rm_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    p_idx_r    <= p_idx_nxt;
    fin_kind_r <= fin_kind_nxt;
    fin_id_r   <= fin_id_nxt;
    fin_ans_r  <= fin_ans_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_ans_r  <= out_ans_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      p_vld_r    <= 1'b0;
      live_r     <= '0;
      slot_cnt_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      p_vld_r    <= p_vld_nxt;
      live_r     <= live_nxt;
      slot_cnt_r <= slot_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

endmodule

[rtl/core/periodic_heartbeat_table.sv]
// Periodic heartbeat table top level: sequencer and timer memory.
// The block holds up to TABLE_DEPTH periodic timers in one memory, in
// insertion order, with a live flag per slot in flip-flops. Every tick, set
// or query walks the occupied slots through the memory's single read port,
// one slot a cycle while no fired result waits on a stalled result port; a
// set or a query ends early at its match. One request is worked on at a
// time; the next one is taken as soon as the last result of the previous
// one sits in the output register. The memory needs no clearing after
// reset: only slots below the occupied count are ever read.
module periodic_heartbeat_table #(
  parameter int TABLE_DEPTH = phb_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = phb_pkg::ID_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  phb_in_if.sink    in_chan,
  phb_out_if.source out_chan
);

  localparam int OWN_W = (ID_BITS < phb_pkg::ID_W) ? ID_BITS : phb_pkg::ID_W;
  localparam int ENT_W = OWN_W + 2 * phb_pkg::PER_W;
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  phb_pkg::ram_ctl_t ram_ctl;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [ENT_W-1:0]  ram_wr_data;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [ENT_W-1:0]  ram_rd_data;

  // Walk sequencer
  phb_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .ram_ctl     (ram_ctl),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // Timer entries: owner, remaining count, period
  phb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_ctl.wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_ctl.rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

[rtl/core/phb_chk.sv]
// Port-level checker for the periodic heartbeat table, with its bind.
module phb_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [phb_pkg::OP_W-1:0]   in_operation,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [phb_pkg::KIND_W-1:0] out_kind,
  input logic [phb_pkg::ID_W-1:0]   out_id,
  input logic [phb_pkg::ANS_W-1:0]  out_answer,
  input logic                       out_last
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_id)
                                && $stable(out_answer) && $stable(out_last))
    else $error("result changed while stalled");

  // A real request closes the input until its walk is over
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation != phb_pkg::OP_NONE) |=> !in_ready)
    else $error("request taken during a walk");

  // Tick done closes the tick with zero id and answer
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == phb_pkg::KIND_DONE) |->
      out_last && (out_id == '0) && (out_answer == '0))
    else $error("malformed tick done");

  // Fired transactions are never last and carry no answer
  a_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == phb_pkg::KIND_FIRED) |-> !out_last && (out_answer == '0))
    else $error("malformed fired transaction");

  // A set status is a single last transaction with a status code
  a_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == phb_pkg::KIND_SET) |->
      out_last && (out_answer < phb_pkg::ANS_W'(4)))
    else $error("malformed set status");

endmodule

bind periodic_heartbeat_table phb_chk u_phb_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_operation (in_chan.operation),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_kind     (out_chan.kind),
  .out_id       (out_chan.fired_or_asked_id),
  .out_answer   (out_chan.answer),
  .out_last     (out_chan.last)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the periodic heartbeat table with a behavioral timer table.
module tb_top;

  localparam int DEPTH         = phb_pkg::TABLE_DEPTH_DEF;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [phb_pkg::KIND_W-1:0] kind;
    logic [phb_pkg::ID_W-1:0]   id;
    logic [phb_pkg::ANS_W-1:0]  answer;
    logic                       last;
  } beat_t;

  logic clk;
  logic rst_n;

  phb_in_if  in_chan ();
  phb_out_if out_chan ();

  periodic_heartbeat_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Behavioral copy of the timer table
  logic [phb_pkg::ID_W-1:0]  tbl_owner  [DEPTH];
  logic [phb_pkg::PER_W-1:0] tbl_left   [DEPTH];
  logic [phb_pkg::PER_W-1:0] tbl_period [DEPTH];
  logic                      tbl_live   [DEPTH];
  int                        tbl_used;

  beat_t due_beats[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int stall_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Queue one expected result transaction
  function automatic void push_beat(phb_pkg::kind_t k, logic [phb_pkg::ID_W-1:0] id,
                                    logic [phb_pkg::ANS_W-1:0] ans, logic last);
    beat_t b;
    b.kind   = k;
    b.id     = id;
    b.answer = ans;
    b.last   = last;
    due_beats.insert(due_beats.size(), b);
  endfunction

  // Walk the table: compact, count down, reload and report fired timers
  function automatic void run_tick();
    int wr;
    wr = 0;
    for (int rd = 0; rd < tbl_used; rd++) begin
      if (tbl_live[rd]) begin
        if (wr != rd) begin
          tbl_owner[wr]  = tbl_owner[rd];
          tbl_left[wr]   = tbl_left[rd];
          tbl_period[wr] = tbl_period[rd];
          tbl_live[wr]   = 1'b1;
          tbl_live[rd]   = 1'b0;
        end
        if (tbl_left[wr] <= 1) begin
          tbl_left[wr] = tbl_period[wr];
          push_beat(phb_pkg::KIND_FIRED, tbl_owner[wr], '0, 1'b0);
        end else begin
          tbl_left[wr] = tbl_left[wr] - 1'b1;
        end
        wr++;
      end
    end
    for (int rd = wr; rd < DEPTH; rd++) tbl_live[rd] = 1'b0;
    tbl_used = wr;
    push_beat(phb_pkg::KIND_DONE, '0, '0, 1'b1);
  endfunction

  // Remove, update or append one timer and return its status
  function automatic phb_pkg::set_st_t run_set(logic [phb_pkg::ID_W-1:0] id,
                                               logic signed [phb_pkg::IV_W-1:0] iv);
    logic [phb_pkg::PER_W-1:0] per;
    logic                      found;
    per   = (iv < 0) ? phb_pkg::PER_W'(1) : iv[phb_pkg::PER_W-1:0];
    found = 1'b0;
    if (per == 0) begin
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_live[i] && tbl_owner[i] == id) begin
          tbl_live[i] = 1'b0;
          found = 1'b1;
        end
      end
      return found ? phb_pkg::ST_REMOVED : phb_pkg::ST_NOT_FOUND;
    end
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_live[i] && tbl_owner[i] == id) begin
        tbl_period[i] = per;
        tbl_left[i]   = per;
        return phb_pkg::ST_OK;
      end
    end
    if (tbl_used >= DEPTH) return phb_pkg::ST_FULL;
    tbl_owner[tbl_used]  = id;
    tbl_period[tbl_used] = per;
    tbl_left[tbl_used]   = per;
    tbl_live[tbl_used]   = 1'b1;
    tbl_used++;
    return phb_pkg::ST_OK;
  endfunction

  // Look up a live timer's period
  function automatic logic [phb_pkg::ANS_W-1:0] run_query(logic [phb_pkg::ID_W-1:0] id);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_live[i] && tbl_owner[i] == id) return tbl_period[i];
    end
    return '0;
  endfunction

  // Work out the results one accepted request causes
  function automatic void apply_request(phb_pkg::op_t op, logic [phb_pkg::ID_W-1:0] id,
                                        logic signed [phb_pkg::IV_W-1:0] iv);
    phb_pkg::set_st_t st;
    case (op)
      phb_pkg::OP_TICK: begin
        run_tick();
      end
      phb_pkg::OP_SET: begin
        st = run_set(id, iv);
        push_beat(phb_pkg::KIND_SET, id, phb_pkg::ANS_W'(st), 1'b1);
      end
      phb_pkg::OP_QUERY: begin
        push_beat(phb_pkg::KIND_QUERY, id, run_query(id), 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  // Send one request transaction, with a random lead-in gap
  task automatic send_item(phb_pkg::op_t op, logic [phb_pkg::ID_W-1:0] id,
                           logic signed [phb_pkg::IV_W-1:0] iv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.object_id <= id;
    in_chan.interval  <= iv;
    do @(posedge clk); while (!in_chan.ready);
    apply_request(op, id, iv);
  endtask

  // Hold off the sender until every expected result has arrived
  task automatic pause_until_drained();
    in_chan.valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Report a bad result transaction
  function automatic void flag_mismatch(string what, beat_t want, beat_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch (%s): expected kind=%0d id=%h answer=%0d last=%0b,",
               $realtime, what, want.kind, want.id, want.answer, want.last,
               " got kind=%0d id=%h answer=%0d last=%0b",
               got.kind, got.id, got.answer, got.last);
  endfunction

  // Random backpressure on the result channel
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.kind   = out_chan.kind;
      got.id     = out_chan.fired_or_asked_id;
      got.answer = out_chan.answer;
      got.last   = out_chan.last;
      if (due_beats.size() == 0) begin
        flag_mismatch("unexpected", '0, got);
      end else begin
        want = due_beats[0];
        due_beats.delete(0);
        if (got.kind !== want.kind || got.id !== want.id ||
            got.answer !== want.answer || got.last !== want.last)
          flag_mismatch("field", want, got);
      end
    end
  end

  // Watchdog: stop when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Every operation, field extremes, lingering removals and compaction
  task automatic test_basic_ops();
    send_item(phb_pkg::OP_QUERY, 16'h0000, 16'sd0);
    send_item(phb_pkg::OP_SET,   16'hFFFF, 16'sd0);
    send_item(phb_pkg::OP_TICK,  16'h0000, 16'sd0);
    send_item(phb_pkg::OP_SET,   16'h0000, 16'sd32767);
    send_item(phb_pkg::OP_SET,   16'hFFFF, -16'sd32768);
    send_item(phb_pkg::OP_SET,   16'h1234, -16'sd1);
    send_item(phb_pkg::OP_SET,   16'h00A5, 16'sd3);
    send_item(phb_pkg::OP_QUERY, 16'hFFFF, 16'sd0);
    send_item(phb_pkg::OP_QUERY, 16'h0000, -16'sd1);
    send_item(phb_pkg::OP_TICK,  16'hFFFF, 16'sd5);
    send_item(phb_pkg::OP_SET,   16'h00A5, 16'sd2);
    send_item(phb_pkg::OP_TICK,  16'h0000, 16'sd0);
    send_item(phb_pkg::OP_TICK,  16'h0000, 16'sd0);
    send_item(phb_pkg::OP_SET,   16'h1234, 16'sd0);
    send_item(phb_pkg::OP_QUERY, 16'h1234, 16'sd0);
    send_item(phb_pkg::OP_SET,   16'h1234, 16'sd0);
    send_item(phb_pkg::OP_NONE,  16'hFFFF, -16'sd1);
    send_item(phb_pkg::OP_SET,   16'h5A5A, 16'sd1);
    send_item(phb_pkg::OP_TICK,  16'h0000, 16'sd0);
    send_item(phb_pkg::OP_SET,   16'h0000, 16'sd0);
    send_item(phb_pkg::OP_TICK,  16'h0000, 16'sd0);
    send_item(phb_pkg::OP_QUERY, 16'h5A5A, 16'sd0);
  endtask

  // Fill the table, then check that a removed slot still counts until a tick
  task automatic test_table_full();
    int n;
    n = 0;
    while (tbl_used < DEPTH) begin
      send_item(phb_pkg::OP_SET, 16'h0100 + 16'(n), 16'($urandom_range(1, 5)));
      n++;
    end
    send_item(phb_pkg::OP_SET,   16'h0100, 16'sd0);
    send_item(phb_pkg::OP_SET,   16'h7777, 16'sd4);
    send_item(phb_pkg::OP_SET,   16'h0101, 16'sd2);
    send_item(phb_pkg::OP_QUERY, tbl_owner[DEPTH-1], 16'sd0);
    send_item(phb_pkg::OP_QUERY, 16'h7777, 16'sd0);
    send_item(phb_pkg::OP_TICK,  16'h0000, 16'sd0);
    send_item(phb_pkg::OP_SET,   16'h7777, 16'sd4);
    send_item(phb_pkg::OP_SET,   16'h8888, 16'sd4);
    send_item(phb_pkg::OP_TICK,  16'h0000, 16'sd0);
    send_item(phb_pkg::OP_TICK,  16'h0000, 16'sd0);
  endtask

  // Random mix of ticks, sets and queries over a small id pool
  task automatic test_random_traffic(int count);
    int                              sent;
    int                              pick;
    phb_pkg::op_t                    op;
    logic [phb_pkg::ID_W-1:0]        id;
    logic signed [phb_pkg::IV_W-1:0] iv;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 30)      op = phb_pkg::OP_TICK;
      else if (pick < 65) op = phb_pkg::OP_SET;
      else if (pick < 95) op = phb_pkg::OP_QUERY;
      else                op = phb_pkg::OP_NONE;
      id = ($urandom_range(99) < 85) ? phb_pkg::ID_W'($urandom_range(0, 15))
                                     : phb_pkg::ID_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 50)      iv = phb_pkg::IV_W'($urandom_range(1, 4));
      else if (pick < 62) iv = '0;
      else if (pick < 72) iv = {1'b1, 15'($urandom)};
      else if (pick < 80) iv = phb_pkg::IV_W'($urandom);
      else                iv = phb_pkg::IV_W'($urandom_range(5, 20));
      send_item(op, id, iv);
      if (op != phb_pkg::OP_NONE) sent++;
    end
  endtask

  // Stimulus sequence and verdict
  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.operation  = phb_pkg::OP_TICK;
    in_chan.object_id  = '0;
    in_chan.interval   = '0;
    out_chan.ready     = 1'b0;
    send_idle_pct      = 8;
    recv_idle_pct      = 74;
    mismatches         = 0;
    stall_cycles       = 0;
    tbl_used           = 0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_owner[i]  = '0;
      tbl_left[i]   = '0;
      tbl_period[i] = '0;
      tbl_live[i]   = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_table_full();
    test_random_traffic(12);
    pause_until_drained();

    send_idle_pct = 74;
    recv_idle_pct = 8;
    test_random_traffic(12);
    pause_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(12);
    pause_until_drained();

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
